@@ rtl/nor_flash_command_sequencer_assert.svh @@
// Assertion macros for the NOR flash command sequencer.
// Both forms take a label, clock, active-low reset, condition, consequence and message.
`ifndef NOR_FLASH_COMMAND_SEQUENCER_ASSERT_SVH
`define NOR_FLASH_COMMAND_SEQUENCER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define NFCS_ASSERT_SAME(label, clk, rstn, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
        else $error(msg);

`define NFCS_ASSERT_NEXT(label, clk, rstn, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
        else $error(msg);

`else

`define NFCS_ASSERT_SAME(label, clk, rstn, cond, cons, msg)

`define NFCS_ASSERT_NEXT(label, clk, rstn, cond, cons, msg)

`endif

`endif

@@ rtl/nfcs_pkg.sv @@
package nfcs_pkg;

    localparam int SECTOR_COUNT = 8;
    localparam int SECTOR_SIZE  = 65536;

    localparam int ADDR_W  = 19;
    localparam int DATA_W  = 8;
    localparam int TICKS_W = 16;
    localparam int STEP_W  = 3;
    localparam int SECT_W  = 3;

    localparam logic [TICKS_W-1:0] ERASE_WAIT_RESET = 16'd800;

    localparam logic [ADDR_W-1:0] ADDR_UNLOCK1 = 19'h555;
    localparam logic [ADDR_W-1:0] ADDR_UNLOCK2 = 19'h2AA;
    localparam logic [ADDR_W-1:0] PROT_OFFSET  = 19'h002;

    localparam logic [DATA_W-1:0] CMD_UNLOCK1  = 8'hAA;
    localparam logic [DATA_W-1:0] CMD_UNLOCK2  = 8'h55;
    localparam logic [DATA_W-1:0] CMD_PROGRAM  = 8'hA0;
    localparam logic [DATA_W-1:0] CMD_ERASE    = 8'h80;
    localparam logic [DATA_W-1:0] CMD_SECTOR   = 8'h30;
    localparam logic [DATA_W-1:0] CMD_CHIP     = 8'h10;
    localparam logic [DATA_W-1:0] CMD_AUTOSEL  = 8'h90;
    localparam logic [DATA_W-1:0] CMD_RESET    = 8'hF0;
    localparam logic [DATA_W-1:0] DATA_NONE    = 8'h00;

    typedef enum logic [2:0] {
        OP_READ    = 3'd0,
        OP_PROGRAM = 3'd1,
        OP_SECTOR  = 3'd2,
        OP_CHIP    = 3'd3,
        OP_RESET   = 3'd4,
        OP_MFR_ID  = 3'd5,
        OP_DEV_ID  = 3'd6,
        OP_SCAN    = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WAIT  = 2'd2
    } cycle_kind_t;

    typedef enum logic [2:0] {
        ASEL_ZERO,
        ASEL_ONE,
        ASEL_UNLOCK1,
        ASEL_UNLOCK2,
        ASEL_TARGET,
        ASEL_SECTOR
    } addr_sel_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    // one bus cycle of a command, as a template
    typedef struct packed {
        cycle_kind_t       kind;
        addr_sel_t         asel;
        logic [DATA_W-1:0] data;
        logic              data_user;  // drive the request's write byte
        logic              fin;        // final cycle of the operation
        logic              grp;        // end of one sector's scan group
    } step_desc_t;

    typedef struct packed {
        logic              running;
        step_desc_t        desc;
        logic [ADDR_W-1:0] sector_base;
        logic              last;
    } seq_stat_t;

    typedef struct packed {
        cycle_kind_t        kind;
        logic [ADDR_W-1:0]  addr;
        logic [DATA_W-1:0]  data;
        logic [TICKS_W-1:0] ticks;
        logic               last;
    } bus_cycle_t;

    function automatic step_desc_t mk_step(cycle_kind_t kind, addr_sel_t asel,
                                           logic [DATA_W-1:0] data, logic data_user,
                                           logic fin, logic grp);
        step_desc_t d;
        d.kind      = kind;
        d.asel      = asel;
        d.data      = data;
        d.data_user = data_user;
        d.fin       = fin;
        d.grp       = grp;
        return d;
    endfunction

    function automatic step_desc_t unlock_step(logic [STEP_W-1:0] step);
        step_desc_t d;
        if (step[0]) begin
            d = mk_step(KIND_WRITE, ASEL_UNLOCK2, CMD_UNLOCK2, 1'b0, 1'b0, 1'b0);
        end else begin
            d = mk_step(KIND_WRITE, ASEL_UNLOCK1, CMD_UNLOCK1, 1'b0, 1'b0, 1'b0);
        end
        return d;
    endfunction

    // Command table: bus cycle template for each operation and step.
    function automatic step_desc_t step_lookup(op_t op, logic [STEP_W-1:0] step);
        step_desc_t d;
        d = mk_step(KIND_WRITE, ASEL_ZERO, DATA_NONE, 1'b0, 1'b1, 1'b0);
        unique case (op)
            OP_READ: begin
                d = mk_step(KIND_READ, ASEL_TARGET, DATA_NONE, 1'b0, 1'b1, 1'b0);
            end
            OP_RESET: begin
                d = mk_step(KIND_WRITE, ASEL_ZERO, CMD_RESET, 1'b0, 1'b1, 1'b0);
            end
            OP_PROGRAM: begin
                unique case (step)
                    3'd0, 3'd1: d = unlock_step(step);
                    3'd2: d = mk_step(KIND_WRITE, ASEL_UNLOCK1, CMD_PROGRAM,
                                      1'b0, 1'b0, 1'b0);
                    default: d = mk_step(KIND_WRITE, ASEL_TARGET, DATA_NONE,
                                         1'b1, 1'b1, 1'b0);
                endcase
            end
            OP_SECTOR, OP_CHIP: begin
                unique case (step)
                    3'd0, 3'd1: d = unlock_step(step);
                    // second unlock pair: steps 3 and 4 map to even, odd
                    3'd3, 3'd4: d = unlock_step(step + 3'd1);
                    3'd2: d = mk_step(KIND_WRITE, ASEL_UNLOCK1, CMD_ERASE,
                                      1'b0, 1'b0, 1'b0);
                    3'd5: begin
                        if (op == OP_SECTOR) begin
                            d = mk_step(KIND_WRITE, ASEL_TARGET, CMD_SECTOR,
                                        1'b0, 1'b0, 1'b0);
                        end else begin
                            d = mk_step(KIND_WRITE, ASEL_UNLOCK1, CMD_CHIP,
                                        1'b0, 1'b0, 1'b0);
                        end
                    end
                    default: d = mk_step(KIND_WAIT, ASEL_ZERO, DATA_NONE,
                                         1'b0, 1'b1, 1'b0);
                endcase
            end
            OP_MFR_ID, OP_DEV_ID: begin
                unique case (step)
                    3'd0, 3'd1: d = unlock_step(step);
                    3'd2: d = mk_step(KIND_WRITE, ASEL_UNLOCK1, CMD_AUTOSEL,
                                      1'b0, 1'b0, 1'b0);
                    3'd3: begin
                        if (op == OP_MFR_ID) begin
                            d = mk_step(KIND_READ, ASEL_ZERO, DATA_NONE,
                                        1'b0, 1'b0, 1'b0);
                        end else begin
                            d = mk_step(KIND_READ, ASEL_ONE, DATA_NONE,
                                        1'b0, 1'b0, 1'b0);
                        end
                    end
                    default: d = mk_step(KIND_WRITE, ASEL_ZERO, CMD_RESET,
                                         1'b0, 1'b1, 1'b0);
                endcase
            end
            OP_SCAN: begin
                unique case (step)
                    3'd0, 3'd1: d = unlock_step(step);
                    3'd2: d = mk_step(KIND_WRITE, ASEL_UNLOCK1, CMD_AUTOSEL,
                                      1'b0, 1'b0, 1'b0);
                    default: d = mk_step(KIND_READ, ASEL_SECTOR, DATA_NONE,
                                         1'b0, 1'b0, 1'b1);
                endcase
            end
            default: begin
                d = mk_step(KIND_WRITE, ASEL_ZERO, DATA_NONE, 1'b0, 1'b1, 1'b0);
            end
        endcase
        return d;
    endfunction

endpackage

@@ rtl/nfcs_seq.sv @@
module nfcs_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  nfcs_pkg::op_t         op,
    input  logic                  advance,
    output nfcs_pkg::seq_stat_t   stat
);
    import nfcs_pkg::*;

    seq_state_t          state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [SECT_W-1:0]   sect_reg, sect_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    step_desc_t          desc;
    logic                last_sect;
    logic                last;

    assign desc      = step_lookup(op, step_reg);
    assign last_sect = (sect_reg == SECT_W'(SECTOR_COUNT - 1));
    assign last      = desc.fin || (desc.grp && last_sect);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE: if (start) state_next = SEQ_RUN;
            SEQ_RUN:  if (advance && last) state_next = SEQ_IDLE;
            default:  state_next = SEQ_IDLE;
        endcase
    end

    // step and sector counters
    always_comb begin
        step_next = step_reg;
        sect_next = sect_reg;
        base_next = base_reg;
        unique case (state_reg)
            SEQ_IDLE: begin
                step_next = '0;
                sect_next = '0;
                base_next = '0;
            end
            SEQ_RUN: begin
                if (advance) begin
                    if (desc.grp) begin
                        // next sector: base wraps at the address width
                        step_next = '0;
                        sect_next = sect_reg + SECT_W'(1);
                        base_next = base_reg + ADDR_W'(SECTOR_SIZE);
                    end else begin
                        step_next = step_reg + STEP_W'(1);
                    end
                end
            end
            default: begin
                step_next = '0;
            end
        endcase
    end

    // status outputs
    always_comb begin
        stat.running     = (state_reg == SEQ_RUN);
        stat.desc        = desc;
        stat.sector_base = base_reg;
        stat.last        = last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEQ_IDLE;
            step_reg  <= '0;
            sect_reg  <= '0;
            base_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            sect_reg  <= sect_next;
            base_reg  <= base_next;
        end
    end

endmodule

@@ rtl/nfcs_cycle_gen.sv @@
module nfcs_cycle_gen (
    input  nfcs_pkg::seq_stat_t                 stat,
    input  logic [nfcs_pkg::ADDR_W-1:0]         target_addr,
    input  logic [nfcs_pkg::DATA_W-1:0]         write_byte,
    input  logic [nfcs_pkg::TICKS_W-1:0]        erase_ticks,
    output nfcs_pkg::bus_cycle_t                cyc
);
    import nfcs_pkg::*;

    logic [ADDR_W-1:0] addr;

    always_comb begin
        unique case (stat.desc.asel)
            ASEL_ZERO:    addr = '0;
            ASEL_ONE:     addr = ADDR_W'(1);
            ASEL_UNLOCK1: addr = ADDR_UNLOCK1;
            ASEL_UNLOCK2: addr = ADDR_UNLOCK2;
            ASEL_TARGET:  addr = target_addr;
            ASEL_SECTOR:  addr = stat.sector_base | PROT_OFFSET;
            default:      addr = '0;
        endcase
    end

    always_comb begin
        cyc.kind  = stat.desc.kind;
        cyc.addr  = addr;
        cyc.data  = stat.desc.data_user ? write_byte : stat.desc.data;
        cyc.ticks = (stat.desc.kind == KIND_WAIT) ? erase_ticks : '0;
        cyc.last  = stat.last;
    end

endmodule

@@ rtl/nor_flash_command_sequencer.sv @@
// Channel   Direction  Handshake           Word
// s_*       in         s_valid / s_ready   one flash operation request
// m_*       out        m_valid / m_ready   one bus cycle, m_last_cycle on the final one
// cfg_*     in         cfg_wr_en           erase wait tick count
//
// A request is taken only while the sequencer is idle; it then emits one bus cycle
// per clock from the command table while m_ready is high: 1 (read, reset), 4 (program),
// 5 (ID read), 7 (erase) or 4*SECTOR_COUNT (scan) bus cycles.
// A low m_ready with a word pending holds the output register and freezes the step counter.
// aresetn is synchronous; the wait tick count returns to 800.
`include "nor_flash_command_sequencer_assert.svh"

module nor_flash_command_sequencer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [nfcs_pkg::TICKS_W-1:0]   cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [2:0]                     s_opcode,
    input  logic [nfcs_pkg::ADDR_W-1:0]    s_target_address,
    input  logic [nfcs_pkg::DATA_W-1:0]    s_write_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_cycle_kind,
    output logic [nfcs_pkg::ADDR_W-1:0]    m_bus_address,
    output logic [nfcs_pkg::DATA_W-1:0]    m_bus_data,
    output logic [nfcs_pkg::TICKS_W-1:0]   m_wait_ticks,
    output logic                           m_last_cycle
);
    import nfcs_pkg::*;

    logic [TICKS_W-1:0] erase_ticks_reg;
    op_t                op_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [DATA_W-1:0]  data_reg;
    logic               m_valid_reg, m_valid_next;
    bus_cycle_t         out_reg;
    bus_cycle_t         cyc;
    seq_stat_t          stat;
    logic               accept;
    logic               load;

    assign s_ready = !stat.running;
    assign accept  = s_valid && s_ready;
    assign load    = stat.running && (!m_valid_reg || m_ready);

    nfcs_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .op      (op_reg),
        .advance (load),
        .stat    (stat)
    );

    nfcs_cycle_gen u_cycle_gen (
        .stat        (stat),
        .target_addr (addr_reg),
        .write_byte  (data_reg),
        .erase_ticks (erase_ticks_reg),
        .cyc         (cyc)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            erase_ticks_reg <= ERASE_WAIT_RESET;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                erase_ticks_reg <= cfg_wr_data;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= op_t'(s_opcode);
            addr_reg <= s_target_address;
            data_reg <= s_write_data;
        end
        if (load) begin
            out_reg <= cyc;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_cycle_kind  = out_reg.kind;
    assign m_bus_address = out_reg.addr;
    assign m_bus_data    = out_reg.data;
    assign m_wait_ticks  = out_reg.ticks;
    assign m_last_cycle  = out_reg.last;

    // while idle, a pending word can only be the final cycle of the previous request
    `NFCS_ASSERT_SAME(a_idle_holds_last, aclk, aresetn, s_ready && m_valid, m_last_cycle, "idle with a non-final word pending")
    // every request emits at least one cycle, so the sequencer must be busy after accept
    `NFCS_ASSERT_NEXT(a_accept_runs, aclk, aresetn, s_valid && s_ready, !s_ready, "request accepted but sequencer not busy")
    // wait cycles only close an erase
    `NFCS_ASSERT_SAME(a_wait_is_last, aclk, aresetn, m_valid && (m_cycle_kind == KIND_WAIT), m_last_cycle, "wait cycle not final")
    // reads and waits drive no data
    `NFCS_ASSERT_SAME(a_no_data_on_read, aclk, aresetn, m_valid && (m_cycle_kind != KIND_WRITE), m_bus_data == '0, "data driven on a non-write cycle")

endmodule
